[rtl/wtc_pkg.sv]
// ----------------------------------------------------------------------------
// wtc_pkg
// Shared types and constants for the wheel turn cascade controller.
// ----------------------------------------------------------------------------
package wtc_pkg;

   localparam int TimeBitsDefault = 32;
   localparam int SlotBitsDefault = 16;

   localparam int CsrAddrBits = 5;
   localparam int CsrDataBits = 32;

   localparam logic [15:0] PositionGainReset  = 16'd90;
   localparam logic [15:0] VelocityGainReset  = 16'd307;
   localparam logic [15:0] VelocityIGainReset = 16'd307;
   localparam logic [15:0] VelocityCapReset   = 16'd4096;
   localparam logic [7:0]  DebounceReset      = 8'd2;

   // register indexes (word address)
   typedef enum logic [2:0] {
      REG_POSITION_GAIN = 3'd0,
      REG_VELOCITY_GAIN = 3'd1,
      REG_VELOCITY_IGAIN = 3'd2,
      REG_VELOCITY_CAP  = 3'd3,
      REG_DEBOUNCE      = 3'd4
   } reg_index_type;

   typedef enum logic [1:0] {
      ACT_TICK  = 2'd0,
      ACT_LEFT  = 2'd1,
      ACT_RIGHT = 2'd2,
      ACT_START = 2'd3
   } action_type;

   typedef struct packed {
      logic [15:0] position_gain;
      logic [15:0] velocity_gain;
      logic [15:0] velocity_igain;
      logic [15:0] velocity_cap;
      logic [7:0]  debounce_ms;
   } cfg_type;

   typedef enum logic [3:0] {
      C_IDLE, C_MSP, C_SP, C_DIV, C_D, C_MK0, C_MK1, C_K,
      C_MP0, C_MP1, C_ACC, C_RND, C_DONE
   } calc_state_type;

   typedef enum logic [2:0] {
      T_IDLE, T_LEFT, T_LWAIT, T_RIGHT, T_RWAIT, T_OUT
   } top_state_type;

endpackage

[rtl/wtc_csr.sv]
// ----------------------------------------------------------------------------
// wtc_csr
// APB register file holding gains, velocity cap and debounce time.
// ----------------------------------------------------------------------------
module wtc_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [wtc_pkg::CsrAddrBits-1:0]  csr_paddr,
   input  logic [wtc_pkg::CsrDataBits-1:0]  csr_pwdata,
   output logic [wtc_pkg::CsrDataBits-1:0]  csr_prdata,
   output logic                             csr_pready,
   output wtc_pkg::cfg_type                 cfg
);
   import wtc_pkg::*;

   cfg_type cfg_ff;
   logic    wr_en;
   reg_index_type idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign idx        = reg_index_type'(csr_paddr[CsrAddrBits-1:2]);
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.position_gain  <= PositionGainReset;
         cfg_ff.velocity_gain  <= VelocityGainReset;
         cfg_ff.velocity_igain <= VelocityIGainReset;
         cfg_ff.velocity_cap   <= VelocityCapReset;
         cfg_ff.debounce_ms    <= DebounceReset;
      end else if (wr_en) begin
         unique case (idx)
            REG_POSITION_GAIN:  cfg_ff.position_gain  <= csr_pwdata[15:0];
            REG_VELOCITY_GAIN:  cfg_ff.velocity_gain  <= csr_pwdata[15:0];
            REG_VELOCITY_IGAIN: cfg_ff.velocity_igain <= csr_pwdata[15:0];
            REG_VELOCITY_CAP:   cfg_ff.velocity_cap   <= csr_pwdata[15:0];
            REG_DEBOUNCE:       cfg_ff.debounce_ms    <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_POSITION_GAIN:  csr_prdata = 32'(cfg_ff.position_gain);
         REG_VELOCITY_GAIN:  csr_prdata = 32'(cfg_ff.velocity_gain);
         REG_VELOCITY_IGAIN: csr_prdata = 32'(cfg_ff.velocity_igain);
         REG_VELOCITY_CAP:   csr_prdata = 32'(cfg_ff.velocity_cap);
         REG_DEBOUNCE:       csr_prdata = 32'(cfg_ff.debounce_ms);
         default:            csr_prdata = '0;
      endcase
   end

endmodule

[rtl/wtc_calc.sv]
// ----------------------------------------------------------------------------
// wtc_calc
// Drive calculation for one wheel: shared 24x17 multiplier and a
// bit-serial restoring divider under a small sequencer.
// ----------------------------------------------------------------------------
module wtc_calc #(
   parameter int TIME_BITS = wtc_pkg::TimeBitsDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [15:0]          err,
   input  logic [15:0]          period,
   input  logic [TIME_BITS-1:0] elapsed,
   input  wtc_pkg::cfg_type     cfg,
   output logic                 done,
   output logic signed [8:0]    drive
);
   import wtc_pkg::*;

   localparam int EW = (TIME_BITS > 34) ? TIME_BITS : 34;
   localparam logic [33:0] KCap = 34'h2_0000_0000;

   calc_state_type state_ff, state_in;

   logic [15:0] err_ff, per_ff, sp_ff;
   logic [EW-1:0] e_ff;
   logic [40:0] prod_ff;
   logic [23:0] mul_a;
   logic [16:0] mul_b;
   logic [16:0] rem_ff, quo_ff, num_ff, rem_t;
   logic [4:0]  cnt_ff;
   logic [23:0] dmag_ff;
   logic        dneg_ff;
   logic [32:0] p0_ff;
   logic [33:0] k_ff;
   logic [57:0] acc_ff;
   logic [8:0]  drive_ff;
   logic [25:0] diff;
   logic [50:0] ksum;
   logic        ebig;
   logic [34:0] rnd;
   logic [7:0]  mag;
   logic [30:0] sp_raw;

   assign done  = (state_ff == C_DONE);
   assign drive = drive_ff;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= C_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         C_IDLE:  if (start) state_in = C_MSP;
         C_MSP:   state_in = C_SP;
         C_SP:    state_in = C_DIV;
         C_DIV:   if (cnt_ff == '0) state_in = C_D;
         C_D:     state_in = C_MK0;
         C_MK0:   state_in = C_MK1;
         C_MK1:   state_in = C_K;
         C_K:     state_in = C_MP0;
         C_MP0:   state_in = C_MP1;
         C_MP1:   state_in = C_ACC;
         C_ACC:   state_in = C_RND;
         C_RND:   state_in = C_DONE;
         C_DONE:  state_in = C_IDLE;
         default: state_in = C_IDLE;
      endcase
   end

   // operand selection for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         C_MSP: begin
            mul_a = 24'(cfg.position_gain);
            mul_b = 17'(err_ff);
         end
         C_MK0: begin
            mul_a = 24'(cfg.velocity_igain);
            mul_b = e_ff[16:0];
         end
         C_MK1: begin
            mul_a = 24'(cfg.velocity_igain);
            mul_b = e_ff[33:17];
         end
         C_MP0: begin
            mul_a = dmag_ff;
            mul_b = k_ff[16:0];
         end
         C_MP1: begin
            mul_a = dmag_ff;
            mul_b = k_ff[33:17];
         end
         default: ;
      endcase
   end

   assign sp_raw = prod_ff[30:0];
   assign rem_t  = {rem_ff[15:0], num_ff[16]};
   assign diff   = {2'b00, sp_ff, 8'h00} - {9'h000, quo_ff};
   assign ebig   = (e_ff >> 34) != '0;
   assign ksum   = 51'(cfg.velocity_gain) + (51'(prod_ff[32:0]) << 17) + 51'(p0_ff);
   assign rnd    = 35'((acc_ff + 58'h80_0000) >> 24);
   assign mag    = (rnd > 35'd255) ? 8'd255 : rnd[7:0];

   always_ff @(posedge clock) begin
      prod_ff <= 41'(mul_a) * 41'(mul_b);
      unique case (state_ff)
         C_IDLE: begin
            err_ff <= err;
            per_ff <= (period == '0) ? 16'd1 : period;
            e_ff   <= EW'(elapsed);
         end
         C_SP: begin
            sp_ff  <= (sp_raw > 31'(cfg.velocity_cap)) ? cfg.velocity_cap : sp_raw[15:0];
            // numerator 65536 + period/2, rounded quotient
            num_ff <= 17'h1_0000 + 17'(per_ff >> 1);
            rem_ff <= '0;
            quo_ff <= '0;
            cnt_ff <= 5'd16;
         end
         C_DIV: begin
            num_ff <= {num_ff[15:0], 1'b0};
            cnt_ff <= cnt_ff - 5'd1;
            if (rem_t >= {1'b0, per_ff}) begin
               rem_ff <= rem_t - {1'b0, per_ff};
               quo_ff <= {quo_ff[15:0], 1'b1};
            end else begin
               rem_ff <= rem_t;
               quo_ff <= {quo_ff[15:0], 1'b0};
            end
         end
         C_D: begin
            dneg_ff <= diff[25];
            dmag_ff <= diff[25] ? 24'(-diff) : diff[23:0];
         end
         C_MK1:   p0_ff <= prod_ff[32:0];
         C_K: begin
            if ((ebig && cfg.velocity_igain != '0) || ksum > 51'(KCap)) k_ff <= KCap;
            else                                                       k_ff <= ksum[33:0];
         end
         C_MP1:   acc_ff <= 58'(prod_ff);
         C_ACC:   acc_ff <= acc_ff + (58'(prod_ff) << 17);
         C_RND:   drive_ff <= dneg_ff ? -{1'b0, mag} : {1'b0, mag};
         default: ;
      endcase
   end

endmodule

[rtl/wheel_turn_cascade_controller.sv]
// ----------------------------------------------------------------------------
// wheel_turn_cascade_controller
// In-place turn of a two-wheel platform: encoder edge counting and a
// cascaded position / velocity loop giving signed drives on every tick.
// ----------------------------------------------------------------------------
//  channel | direction | content
//  req_    | in        | tuser: action; tdata: turn_slots
//  rsp_    | out       | tdata: drives, reached flags, turn done (one per tick)
//  csr_    | in        | APB register file, always ready
//
//  start and edge transfers are handled in the idle state.
//  a tick outside a turn goes straight to the output state; during a turn the shared
//  multiplier and the 17-step divider compute the drive of each running wheel in
//  turn, left first.
//  the result sits in an output register; a new request is taken while it waits.
//  reset is synchronous and returns all state to idle.
// ----------------------------------------------------------------------------
module wheel_turn_cascade_controller #(
   parameter int TIME_BITS = wtc_pkg::TimeBitsDefault,
   parameter int SLOT_BITS = wtc_pkg::SlotBitsDefault
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [15:0]                      req_tdata,  // [15:0] turn_slots
   input  logic [1:0]                       req_tuser,  // [1:0] action
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [8:0] left_drive, [17:9] right_drive, [18] left_reached,
   // [19] right_reached, [20] turn_done, [23:21] zero
   output logic [23:0]                      rsp_tdata,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [wtc_pkg::CsrAddrBits-1:0]  csr_paddr,
   input  logic [wtc_pkg::CsrDataBits-1:0]  csr_pwdata,
   output logic [wtc_pkg::CsrDataBits-1:0]  csr_prdata,
   output logic                             csr_pready
);
   import wtc_pkg::*;

   localparam int CW = (SLOT_BITS > 16) ? SLOT_BITS : 16;
   localparam logic [SLOT_BITS-1:0] SlotMax = '1;

   cfg_type cfg;
   top_state_type state_ff, state_in;

   logic [TIME_BITS-1:0] now_ff, l_stamp_ff, r_stamp_ff;
   logic [SLOT_BITS-1:0] l_slots_ff, r_slots_ff;
   logic [15:0]          l_per_ff, r_per_ff, target_ff;
   logic                 sign_ff, l_stop_ff, r_stop_ff, active_ff;
   logic [8:0]           ld_ff, rd_ff;
   logic                 rsp_valid_ff;
   logic [20:0]          rsp_data_ff;

   logic                 accept;
   action_type           act;
   logic signed [15:0]   ts;
   logic [TIME_BITS-1:0] now_next;
   logic                 l_hit, r_hit;

   logic                 calc_start, calc_done, sel_right;
   logic [15:0]          calc_err, calc_per;
   logic [TIME_BITS-1:0] calc_e;
   logic signed [8:0]    calc_drive;

   wtc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   wtc_calc #(.TIME_BITS(TIME_BITS)) u_calc (
      .clock   (clock),
      .reset   (reset),
      .start   (calc_start),
      .err     (calc_err),
      .period  (calc_per),
      .elapsed (calc_e),
      .cfg     (cfg),
      .done    (calc_done),
      .drive   (calc_drive)
   );

   assign req_tready = (state_ff == T_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign act        = action_type'(req_tuser);
   assign ts         = req_tdata;
   assign now_next   = now_ff + TIME_BITS'(1);
   assign l_hit      = CW'(l_slots_ff) >= CW'(target_ff);
   assign r_hit      = CW'(r_slots_ff) >= CW'(target_ff);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_data_ff};

   assign sel_right  = (state_ff == T_RIGHT) || (state_ff == T_RWAIT);
   assign calc_err   = sel_right ? 16'(CW'(target_ff) - CW'(r_slots_ff))
                                 : 16'(CW'(target_ff) - CW'(l_slots_ff));
   assign calc_per   = sel_right ? r_per_ff : l_per_ff;
   assign calc_e     = sel_right ? now_ff - r_stamp_ff : now_ff - l_stamp_ff;
   assign calc_start = (state_ff == T_LEFT && !l_stop_ff) ||
                       (state_ff == T_RIGHT && !r_stop_ff);

   always_ff @(posedge clock) begin
      if (reset) state_ff <= T_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         T_IDLE:  if (accept && act == ACT_TICK) state_in = active_ff ? T_LEFT : T_OUT;
         T_LEFT:  state_in = l_stop_ff ? T_RIGHT : T_LWAIT;
         T_LWAIT: if (calc_done) state_in = T_RIGHT;
         T_RIGHT: state_in = r_stop_ff ? T_OUT : T_RWAIT;
         T_RWAIT: if (calc_done) state_in = T_OUT;
         T_OUT:   if (!rsp_valid_ff || rsp_tready) state_in = T_IDLE;
         default: state_in = T_IDLE;
      endcase
   end

   function automatic logic [15:0] gap_period(input logic [TIME_BITS-1:0] gap);
      logic [15:0] p;
      if (gap == '0)                        p = 16'd1;
      else if (gap > TIME_BITS'(17'hFFFF))  p = 16'hFFFF;
      else                                  p = gap[15:0];
      return p;
   endfunction

   // edge count, period and time stamp per wheel, turn target and stop flags
   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff     <= '0;
         l_slots_ff <= '0;
         r_slots_ff <= '0;
         l_per_ff   <= 16'd1;
         r_per_ff   <= 16'd1;
         l_stamp_ff <= '0;
         r_stamp_ff <= '0;
         target_ff  <= '0;
         sign_ff    <= 1'b0;
         l_stop_ff  <= 1'b0;
         r_stop_ff  <= 1'b0;
         active_ff  <= 1'b0;
      end else if (accept) begin
         unique case (act)
            ACT_START: begin
               l_slots_ff <= '0;
               r_slots_ff <= '0;
               l_per_ff   <= 16'd1;
               r_per_ff   <= 16'd1;
               l_stamp_ff <= now_ff;
               r_stamp_ff <= now_ff;
               target_ff  <= ts[15] ? 16'(-ts) : 16'(ts);
               sign_ff    <= !(ts > 16'sd0);
               l_stop_ff  <= 1'b0;
               r_stop_ff  <= 1'b0;
               active_ff  <= 1'b1;
            end
            ACT_LEFT: begin
               if (l_slots_ff == '0) begin
                  l_stamp_ff <= now_ff;
                  l_slots_ff <= SLOT_BITS'(1);
               end else if ((now_ff - l_stamp_ff) >= TIME_BITS'(cfg.debounce_ms)) begin
                  if (l_slots_ff != SlotMax) l_slots_ff <= l_slots_ff + SLOT_BITS'(1);
                  l_per_ff   <= gap_period(now_ff - l_stamp_ff);
                  l_stamp_ff <= now_ff;
               end
            end
            ACT_RIGHT: begin
               if (r_slots_ff == '0) begin
                  r_stamp_ff <= now_ff;
                  r_slots_ff <= SLOT_BITS'(1);
               end else if ((now_ff - r_stamp_ff) >= TIME_BITS'(cfg.debounce_ms)) begin
                  if (r_slots_ff != SlotMax) r_slots_ff <= r_slots_ff + SLOT_BITS'(1);
                  r_per_ff   <= gap_period(now_ff - r_stamp_ff);
                  r_stamp_ff <= now_ff;
               end
            end
            ACT_TICK: begin
               now_ff <= now_next;
               if (active_ff) begin
                  if (l_hit) l_stop_ff <= 1'b1;
                  if (r_hit) r_stop_ff <= 1'b1;
                  if ((l_hit || l_stop_ff) && (r_hit || r_stop_ff)) active_ff <= 1'b0;
               end
            end
            default: ;
         endcase
      end
   end

   // drives: left follows the turn sign, right the opposite
   always_ff @(posedge clock) begin
      if (accept) begin
         ld_ff <= '0;
         rd_ff <= '0;
      end else if (calc_done && state_ff == T_LWAIT) begin
         ld_ff <= sign_ff ? -calc_drive : calc_drive;
      end else if (calc_done && state_ff == T_RWAIT) begin
         rd_ff <= sign_ff ? calc_drive : -calc_drive;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == T_OUT && (!rsp_valid_ff || rsp_tready)) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == T_OUT && (!rsp_valid_ff || rsp_tready)) begin
         rsp_data_ff <= {l_stop_ff && r_stop_ff, r_stop_ff, l_stop_ff, rd_ff, ld_ff};
      end
   end

endmodule

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the wheel turn cascade controller. Start, encoder
// edge and tick transfers are streamed in bursts, the drive outputs are
// checked field by field against a cycle-free model of the turn controller
// over several register settings.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import wtc_pkg::*;

   class drive_predictor;
      logic [15:0] pos_gain, vel_gain, vel_igain, vel_cap;
      logic [7:0]  debounce;
      logic [31:0] now;
      logic [15:0] slots[2];
      logic [15:0] period[2];
      logic [31:0] stamp[2];
      logic [15:0] target;
      bit          turn_right, active;
      bit          stopped[2];
      logic [23:0] expected_drives[$];
      int          mismatches;
      int          checked;

      function new();
         pos_gain = PositionGainReset;
         vel_gain = VelocityGainReset;
         vel_igain = VelocityIGainReset;
         vel_cap = VelocityCapReset;
         debounce = DebounceReset;
         now = 0;
         target = 0;
         turn_right = 0;
         active = 0;
         for (int w = 0; w < 2; w++) begin
            slots[w] = 0;
            period[w] = 1;
            stamp[w] = 0;
            stopped[w] = 0;
         end
         mismatches = 0;
         checked = 0;
      endfunction

      function void set_reg(reg_index_type idx, logic [31:0] value);
         case (idx)
            REG_POSITION_GAIN:  pos_gain = value[15:0];
            REG_VELOCITY_GAIN:  vel_gain = value[15:0];
            REG_VELOCITY_IGAIN: vel_igain = value[15:0];
            REG_VELOCITY_CAP:   vel_cap = value[15:0];
            REG_DEBOUNCE:       debounce = value[7:0];
            default: ;
         endcase
      endfunction

      function void take_edge(int w);
         logic [31:0] gap;
         if (slots[w] == 0) begin
            stamp[w] = now;
            slots[w] = 1;
            return;
         end
         gap = now - stamp[w];
         if (gap < debounce) return;
         if (slots[w] != 16'hffff) slots[w]++;
         if (gap == 0) gap = 1;
         if (gap > 65535) gap = 65535;
         period[w] = gap[15:0];
         stamp[w] = now;
      endfunction

      function longint wheel_drive(int w);
         longint unsigned err, sp, p, v, e, k, cap33;
         longint d, prod, mag;
         cap33 = 64'd1 << 33;
         err = longint'(target) - longint'(slots[w]);
         sp = longint'(pos_gain) * err;
         if (sp > longint'(vel_cap)) sp = longint'(vel_cap);
         p = (period[w] == 0) ? 1 : longint'(period[w]);
         v = (65536 + p / 2) / p;
         e = longint'(now - stamp[w]);
         if (vel_igain != 0 && e > cap33 / longint'(vel_igain)) k = cap33;
         else k = longint'(vel_gain) + longint'(vel_igain) * e;
         if (k > cap33) k = cap33;
         d = longint'(sp * 256) - longint'(v);
         prod = d * longint'(k);
         mag = (prod < 0) ? -prod : prod;
         mag = (mag + (longint'(1) << 23)) / (longint'(1) << 24);
         if (mag > 255) mag = 255;
         return (prod < 0) ? -mag : mag;
      endfunction

      function void note_request(action_type act, logic [15:0] turn_slots);
         int     t;
         longint ld, rd;
         case (act)
            ACT_START: begin
               t = $signed(turn_slots);
               for (int w = 0; w < 2; w++) begin
                  slots[w] = 0;
                  period[w] = 1;
                  stamp[w] = now;
                  stopped[w] = 0;
               end
               target = 16'((t < 0) ? -t : t);
               turn_right = !(t > 0);
               active = 1;
            end
            ACT_LEFT:  take_edge(0);
            ACT_RIGHT: take_edge(1);
            default: begin
               now++;
               ld = 0;
               rd = 0;
               if (active) begin
                  if (slots[0] >= target) stopped[0] = 1;
                  if (slots[1] >= target) stopped[1] = 1;
                  if (!stopped[0]) ld = wheel_drive(0);
                  if (!stopped[1]) rd = -wheel_drive(1);
                  if (turn_right) begin
                     ld = -ld;
                     rd = -rd;
                  end
                  if (stopped[0] && stopped[1]) active = 0;
               end
               expected_drives.push_back({3'b000, stopped[0] & stopped[1], stopped[1],
                                          stopped[0], rd[8:0], ld[8:0]});
            end
         endcase
      endfunction

      function void report(string msg);
         mismatches++;
         if (mismatches <= 10) $display("mismatch: %s", msg);
      endfunction

      function void check_drive(logic [23:0] got);
         logic [23:0] exp;
         checked++;
         if (expected_drives.size() == 0) begin
            report($sformatf("unexpected result %h", got));
            return;
         end
         exp = expected_drives.pop_front();
         if (got[8:0] !== exp[8:0])
            report($sformatf("left_drive exp %0d got %0d", $signed(exp[8:0]),
                             $signed(got[8:0])));
         if (got[17:9] !== exp[17:9])
            report($sformatf("right_drive exp %0d got %0d", $signed(exp[17:9]),
                             $signed(got[17:9])));
         if (got[20:18] !== exp[20:18])
            report($sformatf("done/reached flags exp %b got %b", exp[20:18], got[20:18]));
         if (got[23:21] !== 3'b000)
            report($sformatf("pad bits not zero: %b", got[23:21]));
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid, req_tready;
   logic [15:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid, rsp_tready;
   logic [23:0] rsp_tdata;
   logic        csr_psel, csr_penable, csr_pwrite;
   logic [CsrAddrBits-1:0] csr_paddr;
   logic [CsrDataBits-1:0] csr_pwdata, csr_prdata;
   logic        csr_pready;

   drive_predictor pred = new();
   int  burst_left = 0;
   bit  gaps_on = 0;
   bit  hold_request = 0;
   bit  hold_done = 0;
   int  sent = 0;
   int  starts = 0;
   int  edges = 0;

   wheel_turn_cascade_controller uut (.*);

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   initial begin
      #40ms;
      $display("timeout");
      $display("FAILED: results differ");
      $finish;
   end

   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready) pred.check_drive(rsp_tdata);

   // receiver: periodically switching stall pattern, plus one long hold-off
   initial begin
      int mode;
      rsp_tready = 1'b0;
      mode = 0;
      forever begin
         for (int c = 0; c < 150; c++) begin
            @(negedge clock);
            if (hold_request && !hold_done) begin
               rsp_tready <= 1'b0;
               repeat (400) @(negedge clock);
               hold_done = 1;
            end
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= 1'($urandom_range(0, 1));
               default: rsp_tready <= ($urandom_range(0, 4) == 0);
            endcase
         end
         mode = $urandom_range(0, 2);
      end
   end

   task automatic send_item(action_type act, logic [15:0] turn_slots);
      int gap;
      if (gaps_on && burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      req_tvalid <= 1'b1;
      req_tuser <= act;
      req_tdata <= turn_slots;
      do @(posedge clock); while (!req_tready);
      pred.note_request(act, turn_slots);
      sent++;
      if (act == ACT_START) starts++;
      if (act == ACT_LEFT || act == ACT_RIGHT) edges++;
      if (burst_left > 0) burst_left--;
      @(negedge clock);
   endtask

   // wait for every expected result, then let the controller settle
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pred.expected_drives.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(reg_index_type idx, logic [31:0] value);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= CsrAddrBits'(idx) << 2;
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      pred.set_reg(idx, value);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic write_all(logic [15:0] pg, logic [15:0] vg, logic [15:0] ig,
                            logic [15:0] cap, logic [7:0] deb);
      write_reg(REG_POSITION_GAIN, 32'(pg));
      write_reg(REG_VELOCITY_GAIN, 32'(vg));
      write_reg(REG_VELOCITY_IGAIN, 32'(ig));
      write_reg(REG_VELOCITY_CAP, 32'(cap));
      write_reg(REG_DEBOUNCE, 32'(deb));
   endtask

   // mostly short turns that can finish, with noise on the idle data field
   task automatic random_run(int n);
      int          pick, t;
      logic [15:0] noise;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(0, 99);
         noise = 16'($urandom_range(0, 16'hffff));
         if (i == 0 || pick < 3) begin
            if ($urandom_range(0, 9) == 0) t = int'($urandom_range(0, 65534)) - 32767;
            else t = int'($urandom_range(0, 40)) - 20;
            send_item(ACT_START, 16'(t));
         end else if (pick < 58) send_item(ACT_TICK, noise);
         else if (pick < 79) send_item(ACT_LEFT, noise);
         else send_item(ACT_RIGHT, noise);
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = ACT_TICK;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: reset settings, no idling
      send_item(ACT_TICK, 16'hffff);
      send_item(ACT_START, 16'd0);
      send_item(ACT_TICK, 16'h0000);
      send_item(ACT_START, 16'sd32767);
      send_item(ACT_LEFT, 16'h0);
      send_item(ACT_TICK, 16'h0);
      send_item(ACT_LEFT, 16'h0);
      send_item(ACT_TICK, 16'h0);
      send_item(ACT_TICK, 16'h0);
      send_item(ACT_LEFT, 16'h0);
      send_item(ACT_RIGHT, 16'h0);
      send_item(ACT_TICK, 16'h0);
      send_item(ACT_START, -16'sd32767);
      send_item(ACT_TICK, 16'h0);
      send_item(ACT_START, 16'sd1);
      send_item(ACT_LEFT, 16'h0);
      send_item(ACT_RIGHT, 16'h0);
      send_item(ACT_TICK, 16'h0);
      send_item(ACT_TICK, 16'h0);
      // edge while idle, then a longer edge gap
      send_item(ACT_LEFT, 16'h0);
      send_item(ACT_LEFT, 16'h0);
      repeat (20) send_item(ACT_TICK, 16'h0);
      send_item(ACT_LEFT, 16'h0);
      send_item(ACT_START, 16'sd3);
      send_item(ACT_TICK, 16'h0);
      drain();

      gaps_on = 1;
      hold_request = 1;
      random_run(150);
      drain();

      write_all(16'hffff, 16'hffff, 16'hffff, 16'hffff, 8'hff);
      random_run(100);
      drain();

      // zero debounce: back-to-back edges give a zero gap
      write_all(16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'h00);
      send_item(ACT_START, 16'sd5);
      send_item(ACT_RIGHT, 16'h0);
      send_item(ACT_RIGHT, 16'h0);
      send_item(ACT_TICK, 16'h0);
      random_run(100);
      drain();

      write_all(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                8'($urandom_range(0, 3)));
      random_run(120);
      drain();

      write_all(16'd200, 16'd100, 16'd20, 16'd2000, 8'd1);
      random_run(130);
      drain();

      $display("sent %0d transfers (%0d starts, %0d edges), checked %0d results",
               sent, starts, edges, pred.checked);
      $display("settings covered: reset values, all ones, all zeros, random and mid values");
      if (pred.mismatches == 0 && pred.expected_drives.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("%0d mismatches, %0d results missing", pred.mismatches,
                  pred.expected_drives.size());
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

[files.f]
rtl/wtc_pkg.sv
rtl/wtc_csr.sv
rtl/wtc_calc.sv
rtl/wheel_turn_cascade_controller.sv
bench/testbench.sv
